// ===== rtl/scst_pkg.sv =====
package scst_pkg;

	localparam int SPACES      = 16;
	localparam int STACK_DEPTH = 16;

	localparam int SLOT_W  = $clog2(SPACES);
	localparam int LVL_W   = $clog2(STACK_DEPTH);
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = SLOT_W + LVL_W;
	localparam int MEM_D   = SPACES * STACK_DEPTH;

	localparam logic [31:0] THRESHOLD_RESET = 32'd500;

	typedef struct packed {
		logic [63:0] address_space;
		logic [63:0] block_pc;
	} in_word_t;

	typedef struct packed {
		logic [4:0] stack_depth;
		logic       returned;
		logic [3:0] match_level;
		logic [3:0] dropped_count;
		logic       overflow;
		logic       new_space;
		logic       evicted;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_WALK,
		ST_WRITE
	} scst_state_t;

endpackage

// ===== rtl/shadow_call_stack_tracker.sv =====
// Channel   Direction  Handshake          Word
// in        in         in_valid/in_stall   in_word_t   (address_space, block_pc)
// out       out        out_valid/out_stall out_word_t  (depth, match, flags)
// cfg       in         cfg_we              cfg_wdata   (near_threshold)
//
// One word at a time: accept, a slot lookup, a top-down walk of the stack in the
// PC memory (one read and one compare per cycle), then a write-back.
// Reset clears valid bits, depths and the replace pointer; threshold is 500.
// A stalled result waits in the output register; the next word is still taken,
// and only its write-back waits for the previous result to leave.
module shadow_call_stack_tracker
	import scst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	scst_state_t state_q, state_d;

	// Threshold register
	logic [31:0] thr_q;

	// Slot table: keys compared in parallel, one depth per slot
	logic [SPACES-1:0]  slot_valid_q;
	logic [63:0]        slot_key_q   [SPACES];
	logic [DEPTH_W-1:0] slot_depth_q [SPACES];
	logic [SLOT_W-1:0]  repl_q;

	// Current word
	logic [63:0]        key_q, pc_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               new_q, evict_q;
	logic               hit_q;
	logic [LVL_W-1:0]   lvl_q;

	// Walk: entries still to read, and the level of the read in flight
	logic [DEPTH_W-1:0] iss_q;
	logic               pend_s1;
	logic [LVL_W-1:0]   lvl_s1;

	// PC memory
	logic [63:0]        pc_mem [MEM_D];
	logic [63:0]        rd_data_q;
	logic               rd_en, wr_en;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;

	out_word_t          out_q;
	logic               out_valid_q;

	// Lookup logic
	logic               key_hit, free_hit;
	logic [SLOT_W-1:0]  hit_idx, free_idx, sel_slot;
	logic [DEPTH_W-1:0] sel_depth;

	// Walk / write-back logic
	logic [63:0]        pc_gap;
	logic               near;
	logic               walk_miss;
	logic               ovf;
	logic [DEPTH_W-1:0] new_depth;
	logic [LVL_W-1:0]   wr_lvl;
	logic [DEPTH_W-1:0] dropped;
	logic               out_free;

	logic               accept, do_match, do_walk, do_write;

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Associative key match, lowest index first; free slot search likewise
	always_comb begin
		key_hit  = 1'b0;
		hit_idx  = '0;
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = SPACES - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && slot_key_q[i] == key_q) begin
				key_hit = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!slot_valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
		if (key_hit) begin
			sel_slot  = hit_idx;
			sel_depth = slot_depth_q[hit_idx];
		end else begin
			sel_slot  = free_hit ? free_idx : repl_q;
			sel_depth = '0;
		end
	end

	// Distance test on the word returned by the memory
	always_comb begin
		pc_gap = (rd_data_q >= pc_q) ? (rd_data_q - pc_q) : (pc_q - rd_data_q);
		near   = pend_s1 && (pc_gap < {32'd0, thr_q});
	end

	// Result of the walk
	always_comb begin
		ovf = !hit_q && (depth_q == DEPTH_W'(STACK_DEPTH));
		if (hit_q) begin
			new_depth = DEPTH_W'(lvl_q) + DEPTH_W'(1);
			wr_lvl    = lvl_q;
			dropped   = depth_q - DEPTH_W'(lvl_q) - DEPTH_W'(1);
		end else if (ovf) begin
			new_depth = depth_q;
			wr_lvl    = LVL_W'(STACK_DEPTH - 1);
			dropped   = '0;
		end else begin
			new_depth = depth_q + DEPTH_W'(1);
			wr_lvl    = depth_q[LVL_W-1:0];
			dropped   = '0;
		end
	end

	assign walk_miss = (iss_q == '0) && !near;
	assign rd_addr   = {slot_q, LVL_W'(iss_q - DEPTH_W'(1))};
	assign wr_addr   = {slot_q, wr_lvl};

	// Next state and control
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		do_match = 1'b0;
		do_walk  = 1'b0;
		do_write = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				do_match = 1'b1;
				state_d  = (sel_depth == '0) ? ST_WRITE : ST_WALK;
			end
			ST_WALK: begin
				do_walk = 1'b1;
				if (near || walk_miss) begin
					state_d = ST_WRITE;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					do_write = 1'b1;
					wr_en    = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Slot table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			repl_q       <= '0;
			for (int i = 0; i < SPACES; i++) begin
				slot_depth_q[i] <= '0;
			end
		end else if (do_match) begin
			if (!key_hit) begin
				slot_valid_q[sel_slot] <= 1'b1;
				slot_depth_q[sel_slot] <= '0;
				if (!free_hit) begin
					repl_q <= (repl_q == SLOT_W'(SPACES - 1)) ? '0 : repl_q + SLOT_W'(1);
				end
			end
		end else if (do_write) begin
			slot_depth_q[slot_q] <= new_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (do_match && !key_hit) begin
			slot_key_q[sel_slot] <= key_q;
		end
	end

	// Per-word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_word.address_space;
			pc_q  <= in_word.block_pc;
		end
		if (do_match) begin
			slot_q  <= sel_slot;
			depth_q <= sel_depth;
			new_q   <= !key_hit;
			evict_q <= !key_hit && !free_hit;
			lvl_q   <= '0;
		end
		if (do_walk && near) begin
			lvl_q <= lvl_s1;
		end
		if (rd_en) begin
			lvl_s1 <= LVL_W'(iss_q - DEPTH_W'(1));
		end
	end

	// Walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else if (do_match) begin
			iss_q   <= sel_depth;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else if (do_walk) begin
			if (near) begin
				hit_q <= 1'b1;
			end
			pend_s1 <= rd_en;
			if (rd_en) begin
				iss_q <= iss_q - DEPTH_W'(1);
			end
		end
	end

	// PC memory, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= pc_mem[rd_addr];
		end
		if (wr_en) begin
			pc_mem[wr_addr] <= pc_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_write) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			out_q.stack_depth   <= 5'(new_depth);
			out_q.returned      <= hit_q;
			out_q.match_level   <= 4'(lvl_q);
			out_q.dropped_count <= 4'(dropped);
			out_q.overflow      <= ovf;
			out_q.new_space     <= new_q;
			out_q.evicted       <= evict_q;
		end
	end

endmodule
